// ===== src/wads_pkg.sv =====
`default_nettype none

package wads_pkg;

	localparam int ADDR_W     = 48;
	localparam int ADDR_BYTES = 6;
	localparam int HASH_W     = 32;
	localparam int UNIQ_W     = 9;
	localparam int ELAPSED_W  = 16;
	localparam int VERDICT_W  = 2;

	localparam logic [HASH_W-1:0] FNV_OFFSET = 32'h811C_9DC5;
	localparam logic [HASH_W-1:0] FNV_PRIME  = 32'h0100_0193;

	localparam logic [UNIQ_W-1:0]    UNIQUE_MAX  = 9'd511;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;
	localparam logic [ELAPSED_W-1:0] WLEN_RESET  = 16'd1000;

	// input action codes
	localparam logic ACT_ADVERT = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// result kind codes
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	// verdict codes
	localparam logic [VERDICT_W-1:0] VERDICT_NEW     = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_DUP     = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_DROPPED = 2'd2;

	typedef struct packed {
		logic                  kind;
		logic [VERDICT_W-1:0]  verdict;
		logic [UNIQ_W-1:0]     unique_count;
		logic [ELAPSED_W-1:0]  window_elapsed_ms;
	} res_t;

endpackage

`default_nettype wire

// ===== src/wads_front.sv =====
`default_nettype none

module wads_front import wads_pkg::*; #(
	parameter int TABLE_ENTRIES = 256,
	parameter int IDX_W         = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              action,
	input  wire logic [ADDR_W-1:0] bd_addr,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output logic                   cmd_action,
	output logic [ADDR_W-1:0]      cmd_addr,
	output logic [IDX_W-1:0]       cmd_start
);

	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = HASH_W / MOD_BITS;
	localparam int REM_W     = IDX_W + 1;
	localparam logic [2:0]       HASH_LAST = 3'(ADDR_BYTES - 1);
	localparam logic [2:0]       MOD_LAST  = 3'(MOD_STEPS - 1);
	localparam logic [REM_W-1:0] N_REM     = REM_W'(TABLE_ENTRIES);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_HASH = 4'b0010,
		F_MOD  = 4'b0100,
		F_OUT  = 4'b1000
	} fstate_t;

	fstate_t             state_q;
	logic [2:0]          step_q;
	logic                action_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   sh_q;
	logic [HASH_W-1:0]   hash_q;
	logic [REM_W-1:0]    rem_q;
	logic [HASH_W-1:0]   hash_next;
	logic [REM_W-1:0]    rem_next;

	assign in_ready   = (state_q == F_IDLE);
	assign cmd_valid  = (state_q == F_OUT);
	assign cmd_action = action_q;
	assign cmd_addr   = addr_q;
	assign cmd_start  = rem_q[IDX_W-1:0];

	// one FNV-1a round per cycle, top byte first
	assign hash_next = 32'((hash_q ^ {24'b0, sh_q[ADDR_W-1 -: 8]}) * FNV_PRIME);

	// restoring remainder, four hash bits per cycle
	always_comb begin
		logic [REM_W-1:0] r;
		r = rem_q;
		for (int j = 0; j < MOD_BITS; j++) begin
			r = {r[REM_W-2:0], hash_q[HASH_W-1-j]};
			if (r >= N_REM) begin
				r = r - N_REM;
			end
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						step_q  <= '0;
						state_q <= (action == ACT_TICK) ? F_OUT : F_HASH;
					end
				end
				F_HASH: begin
					if (step_q == HASH_LAST) begin
						step_q  <= '0;
						state_q <= F_MOD;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				F_MOD: begin
					if (step_q == MOD_LAST) begin
						state_q <= F_OUT;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				F_OUT: begin
					if (cmd_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					action_q <= action;
					addr_q   <= bd_addr;
					sh_q     <= bd_addr;
					hash_q   <= FNV_OFFSET;
					rem_q    <= '0;
				end
			end
			F_HASH: begin
				hash_q <= hash_next;
				sh_q   <= sh_q << 8;
			end
			F_MOD: begin
				hash_q <= hash_q << MOD_BITS;
				rem_q  <= rem_next;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/wads_queue.sv =====
`default_nettype none

module wads_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/wads_back.sv =====
`default_nettype none

module wads_back import wads_pkg::*; #(
	parameter int TABLE_ENTRIES = 256,
	parameter int IDX_W         = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [ELAPSED_W-1:0] cfg_wr_data,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire logic                 cmd_action,
	input  wire logic [ADDR_W-1:0]    cmd_addr,
	input  wire logic [IDX_W-1:0]     cmd_start,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output res_t                      result
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [4:0] {
		B_CLEAR = 5'b00001,
		B_IDLE  = 5'b00010,
		B_READ  = 5'b00100,
		B_CHECK = 5'b01000,
		B_OUT   = 5'b10000
	} bstate_t;

	bstate_t               state_q;
	logic [IDX_W-1:0]      clr_idx_q;
	logic [IDX_W-1:0]      probe_idx_q;
	logic [IDX_W-1:0]      probe_cnt_q;
	logic [ADDR_W-1:0]     cur_addr_q;
	logic [UNIQ_W-1:0]     unique_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [ELAPSED_W-1:0]  wlen_q;
	logic                  clear_pend_q;
	res_t                  pend_q;
	res_t                  res_q;
	logic                  out_valid_q;

	logic [ADDR_W-1:0]     addr_mem [TABLE_ENTRIES];
	logic                  valid_mem [TABLE_ENTRIES];
	logic [ADDR_W-1:0]     rd_addr_q;
	logic                  rd_valid_q;

	logic [UNIQ_W-1:0]     unique_inc;
	logic [ELAPSED_W-1:0]  elapsed_inc;
	logic                  slot_free;
	logic                  insert;
	logic [IDX_W-1:0]      vwr_idx;
	logic                  vwr_en;
	logic                  vwr_bit;

	assign cmd_ready   = (state_q == B_IDLE);
	assign out_valid   = out_valid_q;
	assign result      = res_q;
	assign slot_free   = !out_valid_q || out_ready;
	assign unique_inc  = (unique_q == UNIQUE_MAX) ? unique_q : unique_q + 9'd1;
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign insert      = (state_q == B_CHECK) && !rd_valid_q;

	assign vwr_en  = (state_q == B_CLEAR) || insert;
	assign vwr_idx = (state_q == B_CLEAR) ? clr_idx_q : probe_idx_q;
	assign vwr_bit = (state_q != B_CLEAR);

	always_ff @(posedge clk) begin
		if (vwr_en) begin
			valid_mem[vwr_idx] <= vwr_bit;
		end
		rd_valid_q <= valid_mem[probe_idx_q];
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			addr_mem[probe_idx_q] <= cur_addr_q;
		end
		rd_addr_q <= addr_mem[probe_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLEAR;
			clr_idx_q    <= '0;
			probe_idx_q  <= '0;
			probe_cnt_q  <= '0;
			cur_addr_q   <= '0;
			unique_q     <= '0;
			elapsed_q    <= '0;
			wlen_q       <= WLEN_RESET;
			clear_pend_q <= 1'b0;
			pend_q       <= '0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				wlen_q <= cfg_wr_data;
			end
			// in B_OUT the output register is reloaded instead
			if (out_valid_q && out_ready && (state_q != B_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					if (clr_idx_q == IDX_LAST) begin
						clr_idx_q <= '0;
						state_q   <= B_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + IDX_W'(1);
					end
				end
				B_IDLE: begin
					if (cmd_valid) begin
						if (cmd_action == ACT_TICK) begin
							if (elapsed_inc >= wlen_q) begin
								pend_q       <= '{KIND_REPORT, VERDICT_NEW, unique_q,
								                  elapsed_inc};
								unique_q     <= '0;
								elapsed_q    <= '0;
								clear_pend_q <= 1'b1;
								state_q      <= B_OUT;
							end else begin
								elapsed_q <= elapsed_inc;
							end
						end else begin
							probe_idx_q <= cmd_start;
							probe_cnt_q <= '0;
							cur_addr_q  <= cmd_addr;
							state_q     <= B_READ;
						end
					end
				end
				B_READ: state_q <= B_CHECK;
				B_CHECK: begin
					if (!rd_valid_q) begin
						unique_q <= unique_inc;
						pend_q   <= '{KIND_VERDICT, VERDICT_NEW, unique_inc, '0};
						state_q  <= B_OUT;
					end else if (rd_addr_q == cur_addr_q) begin
						pend_q  <= '{KIND_VERDICT, VERDICT_DUP, unique_q, '0};
						state_q <= B_OUT;
					end else if (probe_cnt_q == IDX_LAST) begin
						pend_q  <= '{KIND_VERDICT, VERDICT_DROPPED, unique_q, '0};
						state_q <= B_OUT;
					end else begin
						probe_idx_q <= (probe_idx_q == IDX_LAST) ? '0
						                                         : probe_idx_q + IDX_W'(1);
						probe_cnt_q <= probe_cnt_q + IDX_W'(1);
						state_q     <= B_READ;
					end
				end
				B_OUT: begin
					if (slot_free) begin
						res_q        <= pend_q;
						out_valid_q  <= 1'b1;
						clear_pend_q <= 1'b0;
						state_q      <= clear_pend_q ? B_CLEAR : B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/windowed_address_dedup_set_unit.sv =====
// Windowed address dedup set.
// Input beat (in_valid/in_ready): action 0 carries a 48-bit bd_addr to check,
// action 1 is a one-millisecond tick (bd_addr ignored).
// Output beat (out_valid/out_ready): kind 0 is a verdict (new, duplicate,
// dropped when the table is full) with unique_count after any insertion;
// kind 1 is the window report with unique_count and window_elapsed_ms.
// A tick that does not close the window gives no output beat.
// cfg_wr_en/cfg_wr_data write window_length_ms (reset 1000) while idle.
// Front end: FNV-1a hash, one byte a cycle, then modulo TABLE_ENTRIES,
// four bits a cycle; it takes no new input beat until it has handed the
// last one on. A two-beat queue feeds the back end.
// Back end: linear probe of the table memory, B_READ then B_CHECK per slot
// visited, then B_OUT hands the beat to the output register.
// The front end can hash the next advert while the back end still probes
// the last one.
// Reset and every window close start a clearing pass over the valid bits
// of all TABLE_ENTRIES slots; the back end takes no beat during it, the
// front end and queue keep accepting.
// A stalled receiver holds the output register; the back end then waits
// with its next result and the queue and front end fill behind it.
`default_nettype none

module windowed_address_dedup_set_unit import wads_pkg::*; #(
	parameter int TABLE_ENTRIES = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 action,
	input  wire logic [ADDR_W-1:0]    bd_addr,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      kind,
	output logic [VERDICT_W-1:0]      verdict,
	output logic [UNIQ_W-1:0]         unique_count,
	output logic [ELAPSED_W-1:0]      window_elapsed_ms,
	input  wire logic                 cfg_wr_en,
	input  wire logic [ELAPSED_W-1:0] cfg_wr_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CMD_W = 1 + ADDR_W + IDX_W;

	// front end to queue
	logic              f_valid;
	logic              f_ready;
	logic              f_action;
	logic [ADDR_W-1:0] f_addr;
	logic [IDX_W-1:0]  f_start;

	// queue to back end
	logic              b_valid;
	logic              b_ready;
	logic [CMD_W-1:0]  b_data;

	res_t              res;

	wads_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IDX_W         (IDX_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.bd_addr    (bd_addr),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready),
		.cmd_action (f_action),
		.cmd_addr   (f_addr),
		.cmd_start  (f_start)
	);

	wads_queue #(
		.WIDTH (CMD_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_action, f_addr, f_start}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	wads_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IDX_W         (IDX_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (b_valid),
		.cmd_ready   (b_ready),
		.cmd_action  (b_data[CMD_W-1]),
		.cmd_addr    (b_data[CMD_W-2 -: ADDR_W]),
		.cmd_start   (b_data[IDX_W-1:0]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result      (res)
	);

	assign kind              = res.kind;
	assign verdict           = res.verdict;
	assign unique_count      = res.unique_count;
	assign window_elapsed_ms = res.window_elapsed_ms;

endmodule

`default_nettype wire

// ===== tb/sv/windowed_address_dedup_set_unit_test.sv =====
import wads_pkg::*;

// Shadow copy of the dedup set: predicts each result beat and checks what the block returns.
class dedup_scoreboard #(int SLOTS = 256);
	logic [ADDR_W-1:0] stored_addr [SLOTS];
	bit                slot_taken  [SLOTS];
	int unsigned       uniq_cnt;
	int unsigned       elapsed_cnt;
	bit [ELAPSED_W-1:0] window_len;
	res_t              awaited [$];
	int unsigned       mismatches, shown;
	int unsigned       n_new, n_dup, n_drop, n_report;

	function new();
		window_len = WLEN_RESET;
		clear_window();
	endfunction

	function void clear_window();
		foreach (slot_taken[i]) slot_taken[i] = 1'b0;
		uniq_cnt    = 0;
		elapsed_cnt = 0;
	endfunction

	function void set_window(bit [ELAPSED_W-1:0] v);
		window_len = v;
	endfunction

	// FNV-1a over the six bytes, first byte first, folded onto the table
	function int unsigned home_slot(logic [ADDR_W-1:0] a);
		bit [HASH_W-1:0] h;
		h = FNV_OFFSET;
		for (int k = 0; k < ADDR_BYTES; k++)
			h = (h ^ {24'h0, a[8*(ADDR_BYTES-1-k) +: 8]}) * FNV_PRIME;
		return h % SLOTS;
	endfunction

	function bit [VERDICT_W-1:0] probe_insert(logic [ADDR_W-1:0] a);
		int unsigned start, idx;
		start = home_slot(a);
		for (int unsigned step = 0; step < SLOTS; step++) begin
			idx = (start + step) % SLOTS;
			if (!slot_taken[idx]) begin
				stored_addr[idx] = a;
				slot_taken[idx]  = 1'b1;
				if (uniq_cnt < UNIQUE_MAX)
					uniq_cnt++;
				return VERDICT_NEW;
			end
			if (stored_addr[idx] == a)
				return VERDICT_DUP;
		end
		return VERDICT_DROPPED;
	endfunction

	function void note_input(logic act, logic [ADDR_W-1:0] a);
		res_t r;
		if (act == ACT_ADVERT) begin
			r.kind              = KIND_VERDICT;
			r.verdict           = probe_insert(a);
			r.unique_count      = uniq_cnt[UNIQ_W-1:0];
			r.window_elapsed_ms = '0;
			awaited.push_back(r);
		end else begin
			if (elapsed_cnt < ELAPSED_MAX)
				elapsed_cnt++;
			if (elapsed_cnt >= window_len) begin
				r.kind              = KIND_REPORT;
				r.verdict           = VERDICT_NEW;
				r.unique_count      = uniq_cnt[UNIQ_W-1:0];
				r.window_elapsed_ms = elapsed_cnt[ELAPSED_W-1:0];
				awaited.push_back(r);
				clear_window();
			end
		end
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (awaited.size() == 0) begin
			mismatches++;
			if (shown < 10) begin
				shown++;
				$display("unexpected output beat: kind %0d verdict %0d count %0d elapsed %0d",
					got.kind, got.verdict, got.unique_count, got.window_elapsed_ms);
			end
			return;
		end
		want = awaited.pop_front();
		if (want.kind == KIND_REPORT)
			n_report++;
		else if (want.verdict == VERDICT_NEW)
			n_new++;
		else if (want.verdict == VERDICT_DUP)
			n_dup++;
		else
			n_drop++;
		if (got.kind !== want.kind || got.verdict !== want.verdict ||
				got.unique_count !== want.unique_count ||
				got.window_elapsed_ms !== want.window_elapsed_ms) begin
			mismatches++;
			if (shown < 10) begin
				shown++;
				$display("mismatch at %0t: expected kind %0d verdict %0d count %0d elapsed %0d",
					$time, want.kind, want.verdict, want.unique_count, want.window_elapsed_ms);
				$display("                 got      kind %0d verdict %0d count %0d elapsed %0d",
					got.kind, got.verdict, got.unique_count, got.window_elapsed_ms);
			end
		end
	endfunction

	function int unsigned pending();
		return awaited.size();
	endfunction
endclass

module windowed_address_dedup_set_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SLOTS    = 256;
	// far above the longest quiet stretch: a dropped advert walking all 256 slots,
	// a window close with its clearing pass and a stalled receiver together
	localparam int WATCHDOG_LIMIT = 20000;
	// quiet time before a register write: a tick in flight may still be in the pipe
	localparam int SETTLE_CYCLES  = 1500;
	localparam int RECENT_MAX     = 48;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 action      = ACT_ADVERT;
	logic [ADDR_W-1:0]    bd_addr     = '0;
	logic                 out_ready   = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [ELAPSED_W-1:0] cfg_wr_data = '0;
	logic                 in_ready;
	logic                 out_valid;
	logic                 kind;
	logic [VERDICT_W-1:0] verdict;
	logic [UNIQ_W-1:0]    unique_count;
	logic [ELAPSED_W-1:0] window_elapsed_ms;

	dedup_scoreboard #(TABLE_SLOTS) sb;

	logic [ADDR_W-1:0] recent_addrs [$];   // pool of past adverts, source of duplicates
	int unsigned       items_sent;
	int unsigned       windows_used;
	int unsigned       ready_hold;
	int unsigned       quiet_cycles;
	bit                out_calm = 1'b0;    // receiver never stalls while set

	windowed_address_dedup_set_unit #(
		.TABLE_ENTRIES(TABLE_SLOTS)
	) DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.bd_addr           (bd_addr),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.kind              (kind),
		.verdict           (verdict),
		.unique_count      (unique_count),
		.window_elapsed_ms (window_elapsed_ms),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [ADDR_W-1:0] random_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ADDR_W-1:0];
	endfunction

	// Output side: sample the beat with pre-edge values, then pick the next ready.
	always @(posedge clk) begin : result_monitor
		res_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.kind              = kind;
			seen.verdict           = verdict;
			seen.unique_count      = unique_count;
			seen.window_elapsed_ms = window_elapsed_ms;
			sb.check_result(seen);
		end
		if (ready_hold != 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!out_calm && $urandom_range(0, 4) == 0)
				ready_hold = pick_gap(1'b0);
		end
	end

	// Ends the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				quiet_cycles, sb.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	// One input beat. Valid stays high into the next item when there is no gap,
	// so the 0 is only ever scheduled on a step that then waits.
	task automatic push_item(logic act, logic [ADDR_W-1:0] a, bit calm);
		int unsigned gap;
		in_valid <= 1'b1;
		action   <= act;
		bd_addr  <= a;
		do @(posedge clk); while (!in_ready);
		sb.note_input(act, a);
		items_sent++;
		gap = pick_gap(calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender holds off until every predicted beat has come back.
	// Always waits for a clock edge, so a following push never re-raises valid in the same step.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Register writes only when idle: drained, then long enough for a silent tick
	// and any clearing pass to finish.
	task automatic write_window(bit [ELAPSED_W-1:0] v);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.set_window(v);
		windows_used++;
	endtask

	task automatic remember_addr(logic [ADDR_W-1:0] a);
		recent_addrs.push_back(a);
		if (recent_addrs.size() > RECENT_MAX)
			void'(recent_addrs.pop_front());
	endtask

	// Mix of ticks, repeats from the pool and fresh addresses; one hold-off half way.
	task automatic random_phase(int unsigned n, int unsigned tick_pct, bit calm);
		logic [ADDR_W-1:0] a;
		for (int unsigned k = 0; k < n; k++) begin
			if (k == n / 2)
				drain_results();
			if ($urandom_range(0, 99) < tick_pct) begin
				push_item(ACT_TICK, random_addr(), calm);
			end else begin
				if (recent_addrs.size() != 0 && $urandom_range(0, 99) < 45)
					a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
				else
					a = random_addr();
				remember_addr(a);
				push_item(ACT_ADVERT, a, calm);
			end
		end
	endtask

	initial begin : stimulus
		logic [ADDR_W-1:0] filled [$];
		logic [ADDR_W-1:0] a;
		bit [ELAPSED_W-1:0] wl;
		bit calm;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window (1000 ms): all-zero and all-one addresses, repeats, bit patterns
		push_item(ACT_ADVERT, 48'h0000_0000_0000, 1'b0);
		push_item(ACT_ADVERT, 48'hFFFF_FFFF_FFFF, 1'b0);
		push_item(ACT_ADVERT, 48'h0000_0000_0000, 1'b0);
		push_item(ACT_ADVERT, 48'hFFFF_FFFF_FFFF, 1'b0);
		push_item(ACT_ADVERT, 48'hAAAA_AAAA_AAAA, 1'b0);
		push_item(ACT_ADVERT, 48'h5555_5555_5555, 1'b0);
		push_item(ACT_ADVERT, 48'h8000_0000_0000, 1'b0);
		push_item(ACT_ADVERT, 48'h0000_0000_0001, 1'b0);
		// ticks short of the window: no beat back
		push_item(ACT_TICK, 48'hFFFF_FFFF_FFFF, 1'b0);
		push_item(ACT_TICK, 48'h0000_0000_0000, 1'b0);

		// Shortest window: counter already past it, first tick closes
		write_window(16'd1);
		push_item(ACT_TICK, 48'h0000_0000_0000, 1'b0);
		push_item(ACT_ADVERT, 48'h0000_0000_0000, 1'b0);
		push_item(ACT_TICK, 48'hFFFF_FFFF_FFFF, 1'b0);

		// Zero length behaves as one
		write_window(16'd0);
		push_item(ACT_TICK, 48'h1234_5678_9ABC, 1'b0);
		push_item(ACT_TICK, 48'hFEDC_BA98_7654, 1'b0);

		// Longest window: fill every slot, then misses are dropped and hits still found
		write_window(16'hFFFF);
		while (sb.uniq_cnt < TABLE_SLOTS) begin
			a = random_addr();
			filled.push_back(a);
			push_item(ACT_ADVERT, a, 1'b0);
		end
		repeat (12) push_item(ACT_ADVERT, random_addr(), 1'b0);
		repeat (12) push_item(ACT_ADVERT, filled[$urandom_range(0, filled.size() - 1)], 1'b0);
		drain_results();

		// Random part over several window lengths; two phases without any stalls
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: wl = 16'd2;
				1: wl = 16'($urandom_range(3, 12));
				2: wl = 16'($urandom_range(13, 60));
				3: wl = 16'd1;
				4: wl = 16'($urandom_range(61, 300));
				default: wl = 16'($urandom_range(1, 40));
			endcase
			calm = (ph == 2 || ph == 5);
			out_calm <= calm;
			write_window(wl);
			random_phase(200, $urandom_range(10, 50), calm);
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d input beats over %0d window settings, full table included",
			items_sent, windows_used);
		$display("Checked %0d new, %0d duplicate, %0d dropped verdicts and %0d window reports",
			sb.n_new, sb.n_dup, sb.n_drop, sb.n_report);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
